@@ rtl/trte_pkg.sv @@
// Package with the transaction types, codes and constants of the TFTP read transfer engine.
`default_nettype none

package trte_pkg;

  // One input event as it travels on the command channel.
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic [15:0] ack_number;
    logic        file_found;
    logic [31:0] file_bytes;
    logic        name_safe;
    logic [15:0] requested_block_size;
    logic        tsize_requested;
  } cmd_t;

  // One result as it travels on the action channel.
  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] block_number;
    logic [31:0] byte_offset;
    logic [10:0] payload_length;
    logic [1:0]  error_code;
    logic [10:0] block_size_now;
    logic [31:0] total_bytes_sent;
    logic [1:0]  transfer_phase;
    logic        last_of_run;
  } act_t;

  // Configuration register values.
  typedef struct packed {
    logic [10:0] default_block_size;
    logic [15:0] timeout_ms;
    logic [3:0]  max_retries;
  } cfg_t;

  // Write request from the engine to the result queue.
  typedef struct packed {
    logic push;
    logic two;
  } qwr_t;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_ACK   = 3'd1;
  localparam logic [2:0] MODE_RRQ   = 3'd2;
  localparam logic [2:0] MODE_WRQ   = 3'd3;
  localparam logic [2:0] MODE_ABORT = 3'd4;

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_SEND_DATA = 3'd1;
  localparam logic [2:0] ACT_SEND_OACK = 3'd2;
  localparam logic [2:0] ACT_SEND_ERR  = 3'd3;
  localparam logic [2:0] ACT_COMPLETE  = 3'd4;
  localparam logic [2:0] ACT_ABORTED   = 3'd5;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NOT_FOUND = 2'd1;
  localparam logic [1:0] ERR_ACCESS    = 2'd2;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_XFER = 2'd1;
  localparam logic [1:0] PHASE_DONE = 2'd2;
  localparam logic [1:0] PHASE_ERR  = 2'd3;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_MS         = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RETRIES        = 2'd2;

  localparam logic [10:0] RST_DEFAULT_BLOCK_SIZE = 11'd512;
  localparam logic [15:0] RST_TIMEOUT_MS         = 16'd2000;
  localparam logic [3:0]  RST_MAX_RETRIES        = 4'd5;

  localparam logic [10:0] MIN_BLOCK_BYTES = 11'd8;

endpackage

`default_nettype wire

@@ rtl/trte_in_stage.sv @@
// Input register of the TFTP read transfer engine: holds one command transaction.
`default_nettype none

module trte_in_stage
  import trte_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  input  wire logic consume,
  output logic      full,
  output cmd_t      item
);

  logic take;

  assign cmd_stall = full && !consume;
  assign take      = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (take) begin
      full <= 1'b1;
    end else if (consume) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/trte_engine.sv @@
// Transfer state and the single-pass event and timeout logic of the TFTP read transfer engine.
`default_nettype none

module trte_engine
  import trte_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = 1468
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic full,
  input  wire cmd_t item,
  input  wire logic can_load,
  output logic      consume,
  output qwr_t      wr,
  output act_t      r0,
  output act_t      r1
);

  localparam logic [16:0] MaxBlk = 17'(MAX_BLOCK_BYTES);

  // Transfer state
  logic        active;
  logic        oack;
  logic [15:0] cur_block;
  logic [10:0] neg_size;
  logic [31:0] fsize;
  logic [31:0] acked;
  logic [10:0] last_len;
  logic [31:0] last_time;
  logic [3:0]  retry;
  logic [1:0]  phase;

  // State after the event itself
  logic        active_a, oack_a;
  logic [15:0] block_a;
  logic [10:0] size_a, last_len_a;
  logic [31:0] fsize_a, acked_a;
  logic [3:0]  retry_a;
  logic [1:0]  phase_a;

  // State after the timeout check
  logic        active_next, oack_next;
  logic [3:0]  retry_next;
  logic [1:0]  phase_next;
  logic [10:0] last_len_next;
  logic [31:0] last_time_next;

  logic        ev_res, ev_data, ev_oack, ev_send, ev_has;
  logic [2:0]  ev_act;
  logic [1:0]  ev_err;
  logic        to_hit, to_data, to_oack;
  logic        req_ok;
  logic [10:0] eff_dflt;
  logic [31:0] elapsed, left;
  logic [10:0] len;
  act_t        ev_r, to_r;

  always_comb begin
    if (cfg.default_block_size < MIN_BLOCK_BYTES) begin
      eff_dflt = MIN_BLOCK_BYTES;
    end else if ({6'b0, cfg.default_block_size} > MaxBlk) begin
      eff_dflt = MaxBlk[10:0];
    end else begin
      eff_dflt = cfg.default_block_size;
    end
    req_ok = (item.requested_block_size >= 16'(MIN_BLOCK_BYTES)) &&
             ({1'b0, item.requested_block_size} <= MaxBlk);
  end

  always_comb begin
    active_a   = active;
    oack_a     = oack;
    block_a    = cur_block;
    size_a     = neg_size;
    fsize_a    = fsize;
    acked_a    = acked;
    last_len_a = last_len;
    retry_a    = retry;
    phase_a    = phase;
    ev_res     = 1'b0;
    ev_act     = ACT_NONE;
    ev_err     = ERR_NONE;
    ev_data    = 1'b0;
    ev_oack    = 1'b0;
    unique case (item.mode)
      MODE_ACK: begin
        if (active) begin
          if (item.ack_number == 16'd0 && oack) begin
            oack_a  = 1'b0;
            retry_a = 4'd0;
            ev_data = 1'b1;
          end else if (item.ack_number == cur_block) begin
            acked_a = acked + {21'b0, last_len};
            retry_a = 4'd0;
            if (last_len < neg_size) begin
              phase_a  = PHASE_DONE;
              active_a = 1'b0;
              ev_res   = 1'b1;
              ev_act   = ACT_COMPLETE;
            end else begin
              block_a = cur_block + 16'd1;
              ev_data = 1'b1;
            end
          end
        end
      end
      MODE_WRQ: begin
        ev_res = 1'b1;
        ev_act = ACT_SEND_ERR;
        ev_err = ERR_ACCESS;
      end
      MODE_RRQ: begin
        active_a = 1'b0;
        if (!item.name_safe) begin
          ev_res = 1'b1;
          ev_act = ACT_SEND_ERR;
          ev_err = ERR_ACCESS;
        end else if (!item.file_found) begin
          ev_res = 1'b1;
          ev_act = ACT_SEND_ERR;
          ev_err = ERR_NOT_FOUND;
        end else begin
          block_a    = 16'd1;
          fsize_a    = item.file_bytes;
          acked_a    = 32'd0;
          last_len_a = 11'd0;
          retry_a    = 4'd0;
          active_a   = 1'b1;
          size_a     = req_ok ? item.requested_block_size[10:0] : eff_dflt;
          phase_a    = PHASE_XFER;
          oack_a     = req_ok || item.tsize_requested;
          ev_oack    = req_ok || item.tsize_requested;
          ev_data    = !(req_ok || item.tsize_requested);
        end
      end
      MODE_ABORT: begin
        if (active) begin
          active_a = 1'b0;
          oack_a   = 1'b0;
          retry_a  = 4'd0;
          phase_a  = PHASE_IDLE;
          ev_res   = 1'b1;
          ev_act   = ACT_ABORTED;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    // A send in the event itself restarts the timer, so no timeout can follow it.
    ev_send     = ev_data || ev_oack;
    ev_has      = ev_res || ev_send;
    elapsed     = item.now_ms - last_time;
    to_hit      = active_a && !ev_send && (elapsed > {16'b0, cfg.timeout_ms});
    active_next = active_a;
    oack_next   = oack_a;
    retry_next  = retry_a;
    phase_next  = phase_a;
    to_data     = 1'b0;
    to_oack     = 1'b0;
    if (to_hit) begin
      if (retry_a < cfg.max_retries) begin
        retry_next = retry_a + 4'd1;
        to_oack    = oack_a;
        to_data    = !oack_a;
      end else begin
        phase_next  = PHASE_ERR;
        active_next = 1'b0;
        oack_next   = 1'b0;
      end
    end

    left = (acked_a < fsize_a) ? fsize_a - acked_a : 32'd0;
    len  = (left < {21'b0, size_a}) ? left[10:0] : size_a;

    last_len_next  = (ev_data || to_data) ? len : last_len_a;
    last_time_next = (ev_send || to_data || to_oack) ? item.now_ms : last_time;

    ev_r.action           = ev_data ? ACT_SEND_DATA : (ev_oack ? ACT_SEND_OACK : ev_act);
    ev_r.block_number     = block_a;
    ev_r.byte_offset      = ev_data ? acked_a : 32'd0;
    ev_r.payload_length   = ev_data ? len : 11'd0;
    ev_r.error_code       = ev_err;
    ev_r.block_size_now   = size_a;
    ev_r.total_bytes_sent = acked_a;
    ev_r.transfer_phase   = phase_a;
    ev_r.last_of_run      = !to_hit;

    to_r.action           = to_data ? ACT_SEND_DATA : (to_oack ? ACT_SEND_OACK : ACT_ABORTED);
    to_r.block_number     = block_a;
    to_r.byte_offset      = to_data ? acked_a : 32'd0;
    to_r.payload_length   = to_data ? len : 11'd0;
    to_r.error_code       = ERR_NONE;
    to_r.block_size_now   = size_a;
    to_r.total_bytes_sent = acked_a;
    to_r.transfer_phase   = phase_next;
    to_r.last_of_run      = 1'b1;

    r0      = ev_has ? ev_r : to_r;
    r1      = to_r;
    consume = full && (!(ev_has || to_hit) || can_load);
    wr.push = consume && (ev_has || to_hit);
    wr.two  = ev_has && to_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      oack      <= 1'b0;
      cur_block <= 16'd0;
      neg_size  <= 11'd0;
      fsize     <= 32'd0;
      acked     <= 32'd0;
      last_len  <= 11'd0;
      last_time <= 32'd0;
      retry     <= 4'd0;
      phase     <= PHASE_IDLE;
    end else if (consume) begin
      active    <= active_next;
      oack      <= oack_next;
      cur_block <= block_a;
      neg_size  <= size_a;
      fsize     <= fsize_a;
      acked     <= acked_a;
      last_len  <= last_len_next;
      last_time <= last_time_next;
      retry     <= retry_next;
      phase     <= phase_next;
    end
  end

  a_active_phase: assert property (@(posedge clk) disable iff (rst)
    active |-> (phase == PHASE_XFER))
    else $error("transfer active outside the transferring phase");

  a_pair_no_send_first: assert property (@(posedge clk) disable iff (rst)
    (wr.push && wr.two) |-> (r0.action != ACT_SEND_DATA && r0.action != ACT_SEND_OACK))
    else $error("a send was followed by a timeout result for the same event");

endmodule

`default_nettype wire

@@ rtl/trte_out_queue.sv @@
// Two-slot result queue of the TFTP read transfer engine that drives the action channel.
`default_nettype none

module trte_out_queue
  import trte_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire qwr_t wr,
  input  wire act_t r0,
  input  wire act_t r1,
  output logic      can_load,
  output logic      act_valid,
  input  wire logic act_stall,
  output act_t      act
);

  logic [1:0] cnt;
  act_t       tail;
  logic       pop;

  assign act_valid = (cnt != 2'd0);
  assign pop       = act_valid && !act_stall;
  assign can_load  = (cnt == 2'd0) || (cnt == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (wr.push) begin
      cnt <= wr.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) begin
      act  <= r0;
      tail <= r1;
    end else if (pop) begin
      act <= tail;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    wr.push |-> can_load)
    else $error("result pair written into an occupied queue");

  a_head_not_last: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !act.last_of_run)
    else $error("head result marked last while a second result is queued");

endmodule

`default_nettype wire

@@ rtl/tftp_read_transfer_engine_core.sv @@
// Top level of the TFTP read transfer engine: configuration registers and the three stages.
//
// The block is the sender side of a TFTP read transfer with block-size option
// acknowledgement. Software hands it one event per transaction on the command
// channel (cmd, cmd_valid, cmd_stall): a time tick, an ACK, a read request, a
// write request or an abort. For each event it returns zero, one or two result
// transactions on the action channel (act, act_valid, act_stall); the last one
// of an event carries last_of_run.
// An accepted event sits in an input register, where the whole event and
// timeout decision is made, and its results go into a two-slot output queue,
// which registers them before the first is offered on the action channel.
// Events whose results fit in the queue follow back to back; after an event
// with two results, a following event with results waits in the input
// register until the queue is down to its last result and that one is taken.
// When the receiver asserts act_stall, the queue holds its head result and
// fills up, after which cmd_stall rises; nothing is lost or reordered.
// Reset (rst, synchronous) clears the transfer state to idle, empties both
// stages and loads the configuration defaults. Configuration writes on the cfg
// channel are always taken (cfg_ready is tied high) and should only be made
// while no event is in flight.
`default_nettype none

module tftp_read_transfer_engine_core
  import trte_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = 1468
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cmd_valid,
  output logic                        cmd_stall,
  input  wire cmd_t                   cmd,
  output logic                        act_valid,
  input  wire logic                   act_stall,
  output act_t                        act,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  logic full;
  cmd_t item;
  logic consume;
  logic can_load;
  qwr_t wr;
  act_t r0;
  act_t r1;

  // Configuration registers: a write transaction completes in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_block_size <= RST_DEFAULT_BLOCK_SIZE;
      cfg.timeout_ms         <= RST_TIMEOUT_MS;
      cfg.max_retries        <= RST_MAX_RETRIES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEFAULT_BLOCK_SIZE: cfg.default_block_size <= cfg_data[10:0];
        CFG_TIMEOUT_MS:         cfg.timeout_ms         <= cfg_data;
        CFG_MAX_RETRIES:        cfg.max_retries        <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: one command transaction awaiting its decision.
  trte_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .consume   (consume),
    .full      (full),
    .item      (item)
  );

  // Transfer state and the event plus timeout decision for the held command.
  trte_engine #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .full     (full),
    .item     (item),
    .can_load (can_load),
    .consume  (consume),
    .wr       (wr),
    .r0       (r0),
    .r1       (r1)
  );

  // Result queue: up to two results of one event, issued one per cycle while act_stall is low.
  trte_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .r0        (r0),
    .r1        (r1),
    .can_load  (can_load),
    .act_valid (act_valid),
    .act_stall (act_stall),
    .act       (act)
  );

endmodule

`default_nettype wire
